@@ rtl/hlc_pkg.sv @@
`default_nettype none

package hlc_pkg;

    localparam int COORD_W = 32;
    localparam int RGB_W   = 24;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int NUM_AX  = 4;
    localparam int NUM_PL  = 6;
    localparam int EPS_W   = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam int TFRAC  = 30;
    localparam int T_W    = TFRAC + 1;
    localparam int TS_W   = TFRAC + 2;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PL_W   = COORD_W + 2;
    localparam int QB     = TFRAC + 2;
    localparam int REM_W  = PL_W + QB;
    localparam int DIV_LAT = QB + 2;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << TFRAC;
    localparam logic [T_W-1:0] T_SAT = T_ONE + T_W'(1);

    localparam int FIFO_DEPTH = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        PL_ENTER,
        PL_LEAVE,
        PL_PARALLEL
    } pl_class_t;

    typedef struct packed {
        coord_t [NUM_AX-1:0] s;
        coord_t [NUM_AX-1:0] e;
        logic [RGB_W-1:0]    srgb;
        logic [RGB_W-1:0]    ergb;
    } line_t;

    typedef struct packed {
        line_t                   ln;
        pl_class_t [NUM_PL-1:0]  cls;
        logic                    prej;
    } sband_t;

    typedef struct packed {
        logic            ok;
        logic [T_W-1:0]  te;
        logic [T_W-1:0]  tl;
        line_t           ln;
    } job_t;

    typedef struct packed {
        logic                accepted;
        coord_t [NUM_AX-1:0] cs;
        coord_t [NUM_AX-1:0] ce;
        logic [RGB_W-1:0]    srgb;
        logic [RGB_W-1:0]    ergb;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/hlc_div.sv @@
`default_nettype none

module hlc_div (
    input  wire                                aclk,
    input  wire                                en,
    input  wire signed [hlc_pkg::PL_W-1:0]     num,
    input  wire signed [hlc_pkg::PL_W-1:0]     den,
    output logic signed [hlc_pkg::TS_W-1:0]    t
);

    localparam int PL_W  = hlc_pkg::PL_W;
    localparam int QB    = hlc_pkg::QB;
    localparam int REM_W = hlc_pkg::REM_W;
    localparam int TFRAC = hlc_pkg::TFRAC;
    localparam int T_W   = hlc_pkg::T_W;
    localparam int TS_W  = hlc_pkg::TS_W;

    logic [PL_W-1:0]  n_mag;
    logic [PL_W-1:0]  d_mag;
    logic [REM_W-1:0] rem_reg [QB+1];
    logic [PL_W-1:0]  dv_reg  [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             neg_reg [QB+1];
    logic [T_W-1:0]   tmag;
    logic signed [TS_W-1:0] t_reg;

    assign n_mag = num[PL_W-1] ? PL_W'(-num) : PL_W'(num);
    assign d_mag = den[PL_W-1] ? PL_W'(-den) : PL_W'(den);

    // numerator scaled by 2^TFRAC plus half the divisor for round-half-away
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= (REM_W'(n_mag) << TFRAC) + REM_W'(d_mag >> 1);
            dv_reg[0]  <= d_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[PL_W-1] ^ den[PL_W-1];
        end
    end

    // one quotient bit per stage; the top bit flags overflow
    for (genvar k = 1; k <= QB; k++) begin : g_bit
        logic [REM_W-1:0] dsh;
        logic             ge;
        assign dsh = REM_W'(dv_reg[k-1]) << (QB - k);
        assign ge  = rem_reg[k-1] >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                dv_reg[k]  <= dv_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign tmag = (q_reg[QB][QB-1] || (q_reg[QB][QB-2:0] > hlc_pkg::T_ONE))
                ? hlc_pkg::T_SAT : q_reg[QB][T_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= neg_reg[QB] ? -$signed(TS_W'(tmag)) : $signed(TS_W'(tmag));
        end
    end

    assign t = t_reg;

endmodule

`default_nettype wire

@@ rtl/hlc_front.sv @@
`default_nettype none

module hlc_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire [hlc_pkg::EPS_W-1:0]     eps,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire hlc_pkg::line_t          s_line,
    output hlc_pkg::job_t                job,
    output logic                         job_valid,
    input  wire                          job_ready
);

    localparam int LAT    = hlc_pkg::DIV_LAT;
    localparam int NUM_AX = hlc_pkg::NUM_AX;
    localparam int NUM_PL = hlc_pkg::NUM_PL;
    localparam int DIFF_W = hlc_pkg::DIFF_W;
    localparam int PL_W   = hlc_pkg::PL_W;
    localparam int TS_W   = hlc_pkg::TS_W;
    localparam int T_W    = hlc_pkg::T_W;
    localparam int EPS_W  = hlc_pkg::EPS_W;

    logic                    adv;
    logic                    v1_reg, v2_reg, v3_reg;
    logic [LAT-1:0]          sbv_reg;
    hlc_pkg::line_t          ln1_reg, ln2_reg, ln3_reg;
    logic signed [DIFF_W-1:0] d2_reg   [NUM_AX];
    logic signed [PL_W-1:0]   den3_reg [NUM_PL];
    logic signed [PL_W-1:0]   num3_reg [NUM_PL];
    hlc_pkg::sband_t         sb_reg [LAT];
    hlc_pkg::sband_t         sb_next;
    logic signed [PL_W-1:0]  eps_s;
    logic signed [TS_W-1:0]  t_pl [NUM_PL];
    logic signed [TS_W-1:0]  te_s, tl_s;
    hlc_pkg::job_t           job_reg, job_next;
    logic                    job_valid_reg;

    assign adv     = !job_valid_reg || job_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            sbv_reg       <= '0;
            job_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sbv_reg       <= {sbv_reg[LAT-2:0], v3_reg};
            job_valid_reg <= sbv_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ln1_reg <= s_line;
            ln2_reg <= ln1_reg;
            ln3_reg <= ln2_reg;
            for (int a = 0; a < NUM_AX; a++) begin
                d2_reg[a] <= DIFF_W'(ln1_reg.e[a]) - DIFF_W'(ln1_reg.s[a]);
            end
            for (int a = 0; a < NUM_AX - 1; a++) begin
                den3_reg[2*a]   <= PL_W'(d2_reg[a]) + PL_W'(d2_reg[NUM_AX-1]);
                num3_reg[2*a]   <= -PL_W'(ln2_reg.s[a]) - PL_W'(ln2_reg.s[NUM_AX-1]);
                den3_reg[2*a+1] <= PL_W'(d2_reg[NUM_AX-1]) - PL_W'(d2_reg[a]);
                num3_reg[2*a+1] <= PL_W'(ln2_reg.s[a]) - PL_W'(ln2_reg.s[NUM_AX-1]);
            end
            sb_reg[0] <= sb_next;
            for (int k = 1; k < LAT; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
            job_reg <= job_next;
        end
    end

    assign eps_s = $signed({{(PL_W-EPS_W){1'b0}}, eps});

    always_comb begin
        sb_next.ln   = ln3_reg;
        sb_next.prej = 1'b0;
        for (int p = 0; p < NUM_PL; p++) begin
            if (den3_reg[p] > eps_s) begin
                sb_next.cls[p] = hlc_pkg::PL_ENTER;
            end else if (den3_reg[p] < -eps_s) begin
                sb_next.cls[p] = hlc_pkg::PL_LEAVE;
            end else begin
                sb_next.cls[p] = hlc_pkg::PL_PARALLEL;
                if (num3_reg[p] > 0) begin
                    sb_next.prej = 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_PL; g++) begin : g_div
        hlc_div u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (num3_reg[g]),
            .den  (den3_reg[g]),
            .t    (t_pl[g])
        );
    end

    always_comb begin
        te_s = '0;
        tl_s = $signed(TS_W'(hlc_pkg::T_ONE));
        for (int p = 0; p < NUM_PL; p++) begin
            case (sb_reg[LAT-1].cls[p])
                hlc_pkg::PL_ENTER: begin
                    if (t_pl[p] > te_s) te_s = t_pl[p];
                end
                hlc_pkg::PL_LEAVE: begin
                    if (t_pl[p] < tl_s) tl_s = t_pl[p];
                end
                default: ;
            endcase
        end
        job_next.ok = !sb_reg[LAT-1].prej && (te_s <= tl_s);
        job_next.te = te_s[T_W-1:0];
        job_next.tl = tl_s[T_W-1:0];
        job_next.ln = sb_reg[LAT-1].ln;
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

endmodule

`default_nettype wire

@@ rtl/hlc_fifo.sv @@
`default_nettype none

module hlc_fifo #(
    parameter int DEPTH = hlc_pkg::FIFO_DEPTH
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  wire hlc_pkg::job_t   din,
    output logic                 full,
    input  wire                  pop,
    output hlc_pkg::job_t        dout,
    output logic                 empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hlc_pkg::job_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full    = cnt_reg == CW'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    assign dout = mem_reg[rd_reg];

endmodule

`default_nettype wire

@@ rtl/hlc_back.sv @@
`default_nettype none

module hlc_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire hlc_pkg::job_t   job,
    input  wire                  job_valid,
    output logic                 job_pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output hlc_pkg::res_t        res
);

    localparam int NUM_AX  = hlc_pkg::NUM_AX;
    localparam int NUM_CH  = hlc_pkg::NUM_CH;
    localparam int CH_W    = hlc_pkg::CH_W;
    localparam int COORD_W = hlc_pkg::COORD_W;
    localparam int DIFF_W  = hlc_pkg::DIFF_W;
    localparam int T_W     = hlc_pkg::T_W;
    localparam int TFRAC   = hlc_pkg::TFRAC;
    localparam int LO_W    = (DIFF_W + 1) / 2;
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int LOP_W   = T_W + LO_W;
    localparam int HIP_W   = T_W + HI_W;
    localparam int P_W     = T_W + DIFF_W;
    localparam int R_W     = P_W - TFRAC;
    localparam int CP_W    = T_W + CH_W;
    localparam int RC_W    = CP_W - TFRAC;
    localparam int SUM_W   = COORD_W + 3;
    localparam int CS_W    = CH_W + 2;
    localparam logic [P_W-1:0]  HALF  = P_W'(1) << (TFRAC - 1);
    localparam logic [CP_W-1:0] CHALF = CP_W'(1) << (TFRAC - 1);
    localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ok1_reg, ok2_reg, ok3_reg;

    logic [T_W-1:0]        t1_reg     [2];
    hlc_pkg::coord_t       s1_reg     [NUM_AX];
    hlc_pkg::coord_t       s2_reg     [NUM_AX];
    hlc_pkg::coord_t       s3_reg     [NUM_AX];
    logic                  dneg1_reg  [NUM_AX];
    logic                  dneg2_reg  [NUM_AX];
    logic                  dneg3_reg  [NUM_AX];
    logic [DIFF_W-1:0]     dmag1_reg  [NUM_AX];
    logic [CH_W-1:0]       ca1_reg    [NUM_CH];
    logic [CH_W-1:0]       ca2_reg    [NUM_CH];
    logic [CH_W-1:0]       ca3_reg    [NUM_CH];
    logic                  cneg1_reg  [NUM_CH];
    logic                  cneg2_reg  [NUM_CH];
    logic                  cneg3_reg  [NUM_CH];
    logic [CH_W-1:0]       cmag1_reg  [NUM_CH];
    logic [LOP_W-1:0]      plo2_reg   [2][NUM_AX];
    logic [HIP_W-1:0]      phi2_reg   [2][NUM_AX];
    logic [CP_W-1:0]       cp2_reg    [2][NUM_CH];
    logic [R_W-1:0]        r3_reg     [2][NUM_AX];
    logic [RC_W-1:0]       rc3_reg    [2][NUM_CH];
    hlc_pkg::res_t         res_reg, res_next;

    logic signed [DIFF_W-1:0] diff   [NUM_AX];
    logic [CH_W:0]            cdiff  [NUM_CH];
    logic [CH_W:0]            cm9    [NUM_CH];
    logic [P_W-1:0]           psum   [2][NUM_AX];
    logic [CP_W-1:0]          csum   [2][NUM_CH];
    logic [SUM_W-1:0]         vs     [2][NUM_AX];
    logic [CS_W-1:0]          vc     [2][NUM_CH];
    logic [CH_W-1:0]          cout   [2][NUM_CH];
    hlc_pkg::coord_t          cres   [2][NUM_AX];

    assign adv     = !v4_reg || m_ready;
    assign job_pop = adv && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= job_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AX; a++) begin
            diff[a] = DIFF_W'(job.ln.e[a]) - DIFF_W'(job.ln.s[a]);
        end
        for (int c = 0; c < NUM_CH; c++) begin
            cdiff[c] = {1'b0, job.ln.ergb[c*CH_W +: CH_W]}
                     - {1'b0, job.ln.srgb[c*CH_W +: CH_W]};
            cm9[c]   = cdiff[c][CH_W] ? -cdiff[c] : cdiff[c];
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int a = 0; a < NUM_AX; a++) begin
                psum[p][a] = (P_W'(phi2_reg[p][a]) << LO_W) + P_W'(plo2_reg[p][a]) + HALF;
            end
            for (int c = 0; c < NUM_CH; c++) begin
                csum[p][c] = cp2_reg[p][c] + CHALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok1_reg   <= job.ok;
            t1_reg[0] <= job.te;
            t1_reg[1] <= job.tl;
            for (int a = 0; a < NUM_AX; a++) begin
                s1_reg[a]    <= job.ln.s[a];
                dneg1_reg[a] <= diff[a][DIFF_W-1];
                dmag1_reg[a] <= diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
            end
            for (int c = 0; c < NUM_CH; c++) begin
                ca1_reg[c]   <= job.ln.srgb[c*CH_W +: CH_W];
                cneg1_reg[c] <= cdiff[c][CH_W];
                cmag1_reg[c] <= cm9[c][CH_W-1:0];
            end

            ok2_reg <= ok1_reg;
            s2_reg  <= s1_reg;
            dneg2_reg <= dneg1_reg;
            ca2_reg   <= ca1_reg;
            cneg2_reg <= cneg1_reg;
            for (int p = 0; p < 2; p++) begin
                for (int a = 0; a < NUM_AX; a++) begin
                    plo2_reg[p][a] <= LOP_W'(t1_reg[p]) * LOP_W'(dmag1_reg[a][LO_W-1:0]);
                    phi2_reg[p][a] <= HIP_W'(t1_reg[p]) * HIP_W'(dmag1_reg[a][DIFF_W-1:LO_W]);
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    cp2_reg[p][c] <= CP_W'(t1_reg[p]) * CP_W'(cmag1_reg[c]);
                end
            end

            ok3_reg   <= ok2_reg;
            s3_reg    <= s2_reg;
            dneg3_reg <= dneg2_reg;
            ca3_reg   <= ca2_reg;
            cneg3_reg <= cneg2_reg;
            for (int p = 0; p < 2; p++) begin
                for (int a = 0; a < NUM_AX; a++) begin
                    r3_reg[p][a] <= psum[p][a][P_W-1:TFRAC];
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    rc3_reg[p][c] <= csum[p][c][CP_W-1:TFRAC];
                end
            end

            res_reg <= res_next;
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int a = 0; a < NUM_AX; a++) begin
                vs[p][a] = SUM_W'(s3_reg[a])
                         + (dneg3_reg[a] ? -SUM_W'(r3_reg[p][a]) : SUM_W'(r3_reg[p][a]));
                if ((&vs[p][a][SUM_W-1:COORD_W-1]) || !(|vs[p][a][SUM_W-1:COORD_W-1])) begin
                    cres[p][a] = vs[p][a][COORD_W-1:0];
                end else if (vs[p][a][SUM_W-1]) begin
                    cres[p][a] = C_MIN;
                end else begin
                    cres[p][a] = C_MAX;
                end
            end
            for (int c = 0; c < NUM_CH; c++) begin
                vc[p][c] = CS_W'(ca3_reg[c])
                         + (cneg3_reg[c] ? -CS_W'(rc3_reg[p][c]) : CS_W'(rc3_reg[p][c]));
                if (vc[p][c][CS_W-1]) begin
                    cout[p][c] = '0;
                end else if (vc[p][c][CH_W]) begin
                    cout[p][c] = '1;
                end else begin
                    cout[p][c] = vc[p][c][CH_W-1:0];
                end
            end
        end
        res_next = '0;
        if (ok3_reg) begin
            res_next.accepted = 1'b1;
            for (int a = 0; a < NUM_AX; a++) begin
                res_next.cs[a] = cres[0][a];
                res_next.ce[a] = cres[1][a];
            end
            for (int c = 0; c < NUM_CH; c++) begin
                res_next.srgb[c*CH_W +: CH_W] = cout[0][c];
                res_next.ergb[c*CH_W +: CH_W] = cout[1][c];
            end
        end
    end

    assign m_valid = v4_reg;
    assign res     = res_reg;

endmodule

`default_nettype wire

@@ rtl/homogeneous_line_clipper_top.sv @@
// Homogeneous line clipper: one segment per beat on the s_ channel, one
// result beat per segment on the m_ channel, in order.
// Input beat: both endpoints (x, y, z, w signed Q16.16) and packed RGB888.
// Result beat: m_accepted, the two clipped endpoints and their colors; a
// rejected segment returns all coordinate and color fields as zero.
// cfg_we/cfg_wdata write the parallel threshold (raw Q16.16); write it only
// while no segment is in flight.
// Throughput: one segment per cycle while s_ready is high. The six 32-stage
// restoring dividers (one quotient bit per stage) that compute the plane
// parameters make up most of the front-end pipeline.
// The back end (four stages of split multiplies, rounding and saturation)
// sits behind a FIFO_DEPTH-entry queue. While m_valid is high and m_ready is
// low the back end holds its output register and stops draining the queue;
// the front end keeps accepting until the queue is full, then drops s_ready.
// Reset (aresetn low, synchronous) empties all stages and the queue and sets
// the threshold to 1.
`default_nettype none

module homogeneous_line_clipper_top #(
    parameter int FIFO_DEPTH = hlc_pkg::FIFO_DEPTH
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire [hlc_pkg::EPS_W-1:0]      cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [31:0]             s_start_x,
    input  wire signed [31:0]             s_start_y,
    input  wire signed [31:0]             s_start_z,
    input  wire signed [31:0]             s_start_w,
    input  wire [23:0]                    s_start_rgb,
    input  wire signed [31:0]             s_end_x,
    input  wire signed [31:0]             s_end_y,
    input  wire signed [31:0]             s_end_z,
    input  wire signed [31:0]             s_end_w,
    input  wire [23:0]                    s_end_rgb,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_accepted,
    output logic signed [31:0]            m_clip_start_x,
    output logic signed [31:0]            m_clip_start_y,
    output logic signed [31:0]            m_clip_start_z,
    output logic signed [31:0]            m_clip_start_w,
    output logic [23:0]                   m_clip_start_rgb,
    output logic signed [31:0]            m_clip_end_x,
    output logic signed [31:0]            m_clip_end_y,
    output logic signed [31:0]            m_clip_end_z,
    output logic signed [31:0]            m_clip_end_w,
    output logic [23:0]                   m_clip_end_rgb
);

    logic [hlc_pkg::EPS_W-1:0] eps_reg;
    hlc_pkg::line_t            s_line;
    hlc_pkg::job_t             f_job, q_job;
    logic                      f_valid, q_full, q_empty, q_pop;
    hlc_pkg::res_t             res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= hlc_pkg::EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    assign s_line.s    = {s_start_w, s_start_z, s_start_y, s_start_x};
    assign s_line.e    = {s_end_w, s_end_z, s_end_y, s_end_x};
    assign s_line.srgb = s_start_rgb;
    assign s_line.ergb = s_end_rgb;

    hlc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eps       (eps_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_line    (s_line),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (!q_full)
    );

    hlc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_valid),
        .din     (f_job),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_job),
        .empty   (q_empty)
    );

    hlc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (q_job),
        .job_valid (!q_empty),
        .job_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_accepted       = res.accepted;
    assign m_clip_start_x   = res.cs[0];
    assign m_clip_start_y   = res.cs[1];
    assign m_clip_start_z   = res.cs[2];
    assign m_clip_start_w   = res.cs[3];
    assign m_clip_start_rgb = res.srgb;
    assign m_clip_end_x     = res.ce[0];
    assign m_clip_end_y     = res.ce[1];
    assign m_clip_end_z     = res.ce[2];
    assign m_clip_end_w     = res.ce[3];
    assign m_clip_end_rgb   = res.ergb;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |-> m_clip_start_x == 0 && m_clip_end_x == 0 &&
        m_clip_start_w == 0 && m_clip_end_w == 0 &&
        m_clip_start_rgb == 0 && m_clip_end_rgb == 0)
        else $error("rejected segment with nonzero fields");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !q_full |=> !q_empty)
        else $error("queue empty after a push");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 10;
    localparam longint T_UNIT     = longint'(1) << hlc_pkg::TFRAC;

    typedef struct {
        logic signed [31:0] s [4];
        logic signed [31:0] e [4];
        logic [23:0]        srgb;
        logic [23:0]        ergb;
    } segment_t;

    typedef struct {
        logic               accepted;
        logic signed [31:0] cs [4];
        logic signed [31:0] ce [4];
        logic [23:0]        srgb;
        logic [23:0]        ergb;
    } clip_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [hlc_pkg::EPS_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_start_x = '0, s_start_y = '0, s_start_z = '0, s_start_w = '0;
    logic signed [31:0] s_end_x = '0, s_end_y = '0, s_end_z = '0, s_end_w = '0;
    logic [23:0] s_start_rgb = '0, s_end_rgb = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_accepted;
    logic signed [31:0] m_clip_start_x, m_clip_start_y, m_clip_start_z, m_clip_start_w;
    logic signed [31:0] m_clip_end_x, m_clip_end_y, m_clip_end_z, m_clip_end_w;
    logic [23:0] m_clip_start_rgb, m_clip_end_rgb;

    homogeneous_line_clipper_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_start_z(s_start_z), .s_start_w(s_start_w), .s_start_rgb(s_start_rgb),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .s_end_z(s_end_z), .s_end_w(s_end_w), .s_end_rgb(s_end_rgb),
        .m_valid(m_valid), .m_ready(m_ready), .m_accepted(m_accepted),
        .m_clip_start_x(m_clip_start_x), .m_clip_start_y(m_clip_start_y),
        .m_clip_start_z(m_clip_start_z), .m_clip_start_w(m_clip_start_w),
        .m_clip_start_rgb(m_clip_start_rgb),
        .m_clip_end_x(m_clip_end_x), .m_clip_end_y(m_clip_end_y),
        .m_clip_end_z(m_clip_end_z), .m_clip_end_w(m_clip_end_w),
        .m_clip_end_rgb(m_clip_end_rgb)
    );

    always #2 aclk = ~aclk;

    logic [hlc_pkg::EPS_W-1:0] eps_model = hlc_pkg::EPS_RESET;
    segment_t pending_segs [$];
    clip_t    expected_clips [$];
    int  mismatch_count = 0;
    int  idle_pct_src = 35;
    int  idle_pct_snk = 35;
    bit  sink_hold = 1'b0;
    bit  sender_pause = 1'b0;
    bit  timed_out = 1'b0;
    int  quiet_cycles = 0;

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // round(num * 2^30 / den), ties away from zero
    function automatic longint plane_param(longint num, longint den);
        longint q;
        q = ((abs64(num) << hlc_pkg::TFRAC) + abs64(den) / 2) / abs64(den);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint scale_step(longint t, longint d);
        longint r;
        r = (t * abs64(d) + (longint'(1) << (hlc_pkg::TFRAC - 1))) >>> hlc_pkg::TFRAC;
        return d < 0 ? -r : r;
    endfunction

    function automatic logic signed [31:0] lerp_axis(longint a, longint b, longint t);
        longint v;
        v = a + scale_step(t, b - a);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [23:0] lerp_color(logic [23:0] a, logic [23:0] b, longint t);
        logic [23:0] r;
        longint ca, cb, v;
        for (int c = 0; c < 3; c++) begin
            ca = a[c*8 +: 8];
            cb = b[c*8 +: 8];
            v = ca + scale_step(t, cb - ca);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r[c*8 +: 8] = v[7:0];
        end
        return r;
    endfunction

    function automatic bit apply_plane(longint den, longint num, ref longint te, ref longint tl);
        longint eps, t;
        eps = eps_model;
        if (den > eps) begin
            t = plane_param(num, den);
            if (t > tl) return 1'b0;
            if (t > te) te = t;
        end else if (den < -eps) begin
            t = plane_param(num, den);
            if (t < te) return 1'b0;
            if (t < tl) tl = t;
        end else if (num > 0) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic clip_t clip_segment(segment_t g);
        clip_t r;
        longint s [4], e [4], d [4];
        longint te, tl;
        bit ok;
        te = 0;
        tl = T_UNIT;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            s[i] = g.s[i];
            e[i] = g.e[i];
            d[i] = e[i] - s[i];
        end
        for (int i = 0; i < 3 && ok; i++) begin
            ok = apply_plane(d[i] + d[3], -s[i] - s[3], te, tl);
            if (ok) ok = apply_plane(-d[i] + d[3], s[i] - s[3], te, tl);
        end
        r.accepted = ok;
        for (int i = 0; i < 4; i++) begin
            r.cs[i] = '0;
            r.ce[i] = '0;
        end
        r.srgb = '0;
        r.ergb = '0;
        if (ok) begin
            for (int i = 0; i < 4; i++) begin
                r.cs[i] = (te > 0) ? lerp_axis(s[i], e[i], te) : g.s[i];
                r.ce[i] = (tl < T_UNIT) ? lerp_axis(s[i], e[i], tl) : g.e[i];
            end
            r.srgb = (te > 0) ? lerp_color(g.srgb, g.ergb, te) : g.srgb;
            r.ergb = (tl < T_UNIT) ? lerp_color(g.srgb, g.ergb, tl) : g.ergb;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return 32'sh7FFF_FFFF - $urandom_range(0, 16);
            3: return 32'sh8000_0000 + $urandom_range(0, 16);
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic segment_t rand_segment();
        segment_t g;
        logic signed [31:0] w;
        for (int i = 0; i < 4; i++) begin
            g.s[i] = rand_coord();
            g.e[i] = rand_coord();
        end
        // mostly positive w in a sane range so clipping actually happens
        if ($urandom_range(0, 3) != 0) begin
            w = $urandom_range(32'h0000_1000, 32'h0004_0000);
            g.s[3] = w;
            g.e[3] = $urandom_range(32'h0000_1000, 32'h0004_0000);
            for (int i = 0; i < 3; i++) begin
                g.s[i] = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
                g.e[i] = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            end
        end
        g.srgb = $urandom;
        g.ergb = $urandom;
        return g;
    endfunction

    function automatic segment_t make_segment(int sx, int sy, int sz, int sw,
                                              int ex, int ey, int ez, int ew,
                                              logic [23:0] sc, logic [23:0] ec);
        segment_t g;
        g.s[0] = sx; g.s[1] = sy; g.s[2] = sz; g.s[3] = sw;
        g.e[0] = ex; g.e[1] = ey; g.e[2] = ez; g.e[3] = ew;
        g.srgb = sc;
        g.ergb = ec;
        return g;
    endfunction

    function automatic bit same_clip(clip_t a, clip_t b);
        if (a.accepted !== b.accepted || a.srgb !== b.srgb || a.ergb !== b.ergb) return 1'b0;
        for (int i = 0; i < 4; i++)
            if (a.cs[i] !== b.cs[i] || a.ce[i] !== b.ce[i]) return 1'b0;
        return 1'b1;
    endfunction

    // driver
    always @(posedge aclk) begin
        segment_t g;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_segs.size() > 0 && !sender_pause &&
                $urandom_range(0, 99) >= idle_pct_src) begin
                g = pending_segs.pop_front();
                s_valid <= 1'b1;
                s_start_x <= g.s[0]; s_start_y <= g.s[1];
                s_start_z <= g.s[2]; s_start_w <= g.s[3]; s_start_rgb <= g.srgb;
                s_end_x <= g.e[0]; s_end_y <= g.e[1];
                s_end_z <= g.e[2]; s_end_w <= g.e[3]; s_end_rgb <= g.ergb;
                expected_clips.push_back(clip_segment(g));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink ready
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !sink_hold && ($urandom_range(0, 99) >= idle_pct_snk);
    end

    // monitor
    always @(posedge aclk) begin
        clip_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.accepted = m_accepted;
            got.cs[0] = m_clip_start_x; got.cs[1] = m_clip_start_y;
            got.cs[2] = m_clip_start_z; got.cs[3] = m_clip_start_w;
            got.ce[0] = m_clip_end_x; got.ce[1] = m_clip_end_y;
            got.ce[2] = m_clip_end_z; got.ce[3] = m_clip_end_w;
            got.srgb = m_clip_start_rgb;
            got.ergb = m_clip_end_rgb;
            if (expected_clips.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result beat at %0t", $realtime);
            end else begin
                want = expected_clips.pop_front();
                if (!same_clip(got, want)) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: mismatch at %0t", $realtime);
                        $display("  exp acc=%0b s=%0h %0h %0h %0h rgb=%06h e=%0h %0h %0h %0h rgb=%06h",
                                 want.accepted, want.cs[0], want.cs[1], want.cs[2],
                                 want.cs[3], want.srgb, want.ce[0], want.ce[1],
                                 want.ce[2], want.ce[3], want.ergb);
                        $display("  got acc=%0b s=%0h %0h %0h %0h rgb=%06h e=%0h %0h %0h %0h rgb=%06h",
                                 got.accepted, got.cs[0], got.cs[1], got.cs[2],
                                 got.cs[3], got.srgb, got.ce[0], got.ce[1],
                                 got.ce[2], got.ce[3], got.ergb);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || sink_hold || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_segs.size() > 0 || s_valid || expected_clips.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_eps(logic [hlc_pkg::EPS_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        eps_model = v;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_segs.push_back(rand_segment());
    endtask

    initial begin
        logic [hlc_pkg::EPS_W-1:0] eps_set [5];
        eps_set = '{16'd0, 16'hFFFF, 16'd1, 16'h0100, 16'd7};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        pending_segs.push_back(make_segment(0, 0, 0, 32'h10000, 32'h8000, 0, 0, 32'h10000,
                                            24'hFF0000, 24'h00FF00));
        pending_segs.push_back(make_segment(-32'h20000, 0, 0, 32'h10000, 32'h20000, 0, 0,
                                            32'h10000, 24'h000000, 24'hFFFFFF));
        pending_segs.push_back(make_segment(32'h20000, 0, 0, 32'h10000, 32'h30000, 0, 0,
                                            32'h10000, 24'h123456, 24'h654321));
        pending_segs.push_back(make_segment(0, 32'h20000, 0, 32'h10000, 0, 32'h20000, 0,
                                            32'h10000, 24'hABCDEF, 24'h010203));
        pending_segs.push_back(make_segment(0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'h000000));
        pending_segs.push_back(make_segment(0, 0, -32'h30000, 32'h10000, 0, 0, 32'h30000,
                                            32'h10000, 24'h00FF00, 24'hFF00FF));
        pending_segs.push_back(make_segment(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                            32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                            32'h80000000, 32'h80000000, 24'hFFFFFF, 24'h0));
        pending_segs.push_back(make_segment(32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                            0, 0, 32'h7FFFFFFF, 24'h0, 24'hFFFFFF));
        pending_segs.push_back(make_segment(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10001,
                                            24'h808080, 24'h7F7F7F));
        pending_segs.push_back(make_segment(32'h80000000, 32'h80000000, 32'h80000000,
                                            32'h80000000, 32'h80000000, 32'h80000000,
                                            32'h80000000, 32'h80000000, 24'h1, 24'h2));
        pending_segs.push_back(make_segment(-32'h18000, -32'h18000, 0, 32'h10000, 32'h18000,
                                            32'h18000, 0, 32'h10000, 24'hFF00FF, 24'h00FF00));
        queue_random(10);
        wait_drained();

        foreach (eps_set[k]) begin
            write_eps(eps_set[k]);
            idle_pct_src = 35;
            idle_pct_snk = 35;
            queue_random(200);
            wait_drained();
        end

        // no idling, then back-pressure with the sender still offering beats
        write_eps(16'h0003);
        idle_pct_src = 0;
        idle_pct_snk = 0;
        queue_random(150);
        sink_hold = 1'b1;
        repeat (300) @(posedge aclk);
        sink_hold = 1'b0;
        while (pending_segs.size() > 0) @(posedge aclk);
        // sender pauses until all results are back
        sender_pause = 1'b1;
        queue_random(50);
        while (s_valid || expected_clips.size() > 0) @(posedge aclk);
        sender_pause = 1'b0;
        idle_pct_src = 35;
        idle_pct_snk = 35;
        queue_random(250);
        wait_drained();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
